### design/arq_pkg.sv
`default_nettype none

package arq_pkg;

	// Sizes of the task table and of the CPU set.
	localparam int MAX_TASKS = 16;
	localparam int NUM_CPUS  = 2;

	// Field widths fixed by the interface.
	localparam int SLOT_W = 4;
	localparam int MASK_W = 2;

	// Queue position and queue length widths.
	localparam int IDX_W = $clog2(MAX_TASKS);
	localparam int LEN_W = $clog2(MAX_TASKS + 1);

	// Affinity after reset: every CPU allowed.
	localparam logic [7:0]          ALL_CPUS_MASK = 8'h03;
	localparam logic [NUM_CPUS-1:0] RESET_MASK    = ALL_CPUS_MASK[NUM_CPUS-1:0];

	typedef enum logic [1:0] {
		FUNC_ENQUEUE  = 2'd0,
		FUNC_REMOVE   = 2'd1,
		FUNC_SET_MASK = 2'd2,
		FUNC_SCHEDULE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		func_t             func;
		logic [SLOT_W-1:0] task_slot;
		logic [MASK_W-1:0] new_mask;
		logic              cpu_index;
		logic              prev_is_task;
		logic              prev_running;
	} arq_in_t;

	typedef struct packed {
		logic [SLOT_W-1:0] chosen_slot;
		logic              chose_idle;
		logic              ignored;
	} arq_out_t;

	// Finished result handed from the sequencer to the output register.
	typedef struct packed {
		logic     valid;
		arq_out_t result;
	} arq_done_t;

	// Port signals of the queue order memory.
	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [SLOT_W-1:0] wdata;
		logic [IDX_W-1:0]  raddr;
	} arq_ram_req_t;

endpackage

`default_nettype wire

### design/arq_ram.sv
`default_nettype none

module arq_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### design/arq_seq.sv
`default_nettype none

module arq_seq (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire arq_pkg::arq_in_t              start_item,
	input  wire logic                          out_free,
	input  wire logic [arq_pkg::SLOT_W-1:0]    ram_rdata,
	output arq_pkg::arq_ram_req_t              ram_req,
	output logic                               busy,
	output arq_pkg::arq_done_t                 done
);

	import arq_pkg::*;

	state_t            state_q, state_d;
	arq_in_t           item_q;
	logic [LEN_W-1:0]  len_q;
	logic [MAX_TASKS-1:0] in_queue_q;
	logic [NUM_CPUS-1:0]  affinity_q [MAX_TASKS];
	logic [LEN_W-1:0]  rd_q;
	logic              valid_s1;
	logic [IDX_W-1:0]  pos_s1;
	logic              found_q;
	logic [SLOT_W-1:0] chosen_q;
	logic              ign_q;

	logic             slot_ok;
	logic [IDX_W-1:0] slot_idx;
	logic             queued;
	logic             requeue;
	logic             push;
	logic             ign_exec;
	logic             cpu_ok;
	logic             scan_go;
	logic             issue;
	logic             hit;
	logic             scan_end;
	logic [IDX_W-1:0] data_idx;

	// Decode of the captured item.
	always_comb begin
		slot_ok  = {1'b0, item_q.task_slot} < LEN_W'(MAX_TASKS);
		slot_idx = item_q.task_slot[IDX_W-1:0];
		queued   = in_queue_q[slot_idx];
		requeue  = (item_q.func == FUNC_SCHEDULE) && item_q.prev_is_task
			&& item_q.prev_running && slot_ok;
		push     = ((item_q.func == FUNC_ENQUEUE && slot_ok) || requeue) && !queued
			&& (len_q < LEN_W'(MAX_TASKS));
		ign_exec = (item_q.func == FUNC_ENQUEUE && (!slot_ok || queued))
			|| (item_q.func == FUNC_REMOVE && (!slot_ok || !queued))
			|| (requeue && queued);
		cpu_ok   = 32'(item_q.cpu_index) < NUM_CPUS;
		scan_go  = (item_q.func == FUNC_REMOVE && slot_ok && queued)
			|| (item_q.func == FUNC_SCHEDULE && cpu_ok);
	end

	// Scan: one read per cycle, data checked in the cycle after its read.
	always_comb begin
		issue    = (state_q == ST_SCAN) && (rd_q < len_q);
		data_idx = ram_rdata[IDX_W-1:0];
		if (item_q.func == FUNC_REMOVE) begin
			hit = valid_s1 && !found_q && (ram_rdata == item_q.task_slot);
		end else begin
			hit = valid_s1 && !found_q && affinity_q[data_idx][item_q.cpu_index];
		end
		scan_end = !issue && !valid_s1;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = scan_go ? ST_SCAN : ST_DONE;
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs: memory port, busy flag and the finished result.
	always_comb begin
		ram_req       = '0;
		ram_req.raddr = rd_q[IDX_W-1:0];
		done          = '0;
		busy          = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
			end
			ST_EXEC: begin
				// Append at the tail.
				ram_req.we    = push;
				ram_req.waddr = len_q[IDX_W-1:0];
				ram_req.wdata = item_q.task_slot;
			end
			ST_SCAN: begin
				// Entries behind the taken one move down by one place.
				ram_req.we    = valid_s1 && found_q;
				ram_req.waddr = pos_s1 - IDX_W'(1);
				ram_req.wdata = ram_rdata;
			end
			ST_DONE: begin
				done.valid = out_free;
				if (item_q.func == FUNC_SCHEDULE) begin
					done.result.chosen_slot = found_q ? chosen_q : '0;
					done.result.chose_idle  = !found_q;
				end
				done.result.ignored = ign_q;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// Control state and the queue bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			len_q      <= '0;
			in_queue_q <= '0;
			rd_q       <= '0;
			valid_s1   <= 1'b0;
			found_q    <= 1'b0;
			for (int i = 0; i < MAX_TASKS; i++) begin
				affinity_q[i] <= RESET_MASK;
			end
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;
			if (issue) begin
				rd_q <= rd_q + LEN_W'(1);
			end
			if (state_q == ST_EXEC) begin
				rd_q    <= '0;
				found_q <= 1'b0;
				if (push) begin
					len_q                <= len_q + LEN_W'(1);
					in_queue_q[slot_idx] <= 1'b1;
				end
				if (item_q.func == FUNC_SET_MASK && slot_ok) begin
					affinity_q[slot_idx] <= item_q.new_mask[NUM_CPUS-1:0];
				end
			end
			if (hit) begin
				found_q              <= 1'b1;
				in_queue_q[data_idx] <= 1'b0;
			end
			if (state_q == ST_SCAN && scan_end && found_q) begin
				len_q <= len_q - LEN_W'(1);
			end
		end
	end

	// Item capture and the payload of the pending result.
	always_ff @(posedge clk) begin
		if (start && state_q == ST_IDLE) begin
			item_q <= start_item;
		end
		if (state_q == ST_EXEC) begin
			ign_q <= ign_exec;
		end
		if (hit) begin
			chosen_q <= ram_rdata;
		end
		pos_s1 <= rd_q[IDX_W-1:0];
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_TASKS))
		else $error("queue length above table size");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ($countones(in_queue_q) == 32'(len_q)))
		else $error("queued flags disagree with queue length");

	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done.valid |-> out_free)
		else $error("result finished while output register full");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ({1'b0, pos_s1} < len_q))
		else $error("scan read beyond queue tail");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done.valid && done.result.chose_idle) |-> (done.result.chosen_slot == '0))
		else $error("idle pick with nonzero slot");

endmodule

`default_nettype wire

### design/affinity_ready_queue_unit.sv
// Affinity ready queue: a FIFO of task slots with a CPU affinity mask per slot.
// Request channel (req_valid, req_ready, req_item) carries one command: enqueue,
// remove, set affinity mask, or schedule for one CPU. Response channel
// (rsp_valid, rsp_ready, rsp_item) returns exactly one result per request.
// A command is taken only while the sequencer is idle; one request at a time.
// Enqueue, set mask and ignored removals pass from the execute state to the
// done state, after which the result is registered and the next request can
// transfer. Remove and schedule walk the queue order memory in a scan state,
// one entry per cycle through its single read port, so their time grows with
// the queue length, up to 16 queued slots; a schedule on an empty queue passes
// through the scan state without a read.
// The result sits in an output register; a new request is accepted while it
// waits, and the sequencer only holds its next result when that register is
// still full and rsp_ready stays low.
// Reset (arst_n low) empties the queue and sets every mask to all CPUs; the
// queue order memory needs no clearing since only entries below the length
// are read.
`default_nettype none

module affinity_ready_queue_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire arq_pkg::arq_in_t  req_item,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output arq_pkg::arq_out_t      rsp_item
);

	import arq_pkg::*;

	arq_ram_req_t      ram_req;
	logic [SLOT_W-1:0] ram_rdata;
	logic              busy;
	arq_done_t         done;
	logic              start;
	logic              out_free;
	logic              rsp_valid_q;
	arq_out_t          rsp_item_q;

	// Handshake glue.
	assign req_ready = !busy;
	assign start     = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;

	// Queue order memory.
	arq_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(MAX_TASKS)
	) u_order (
		.clk  (clk),
		.we   (ram_req.we),
		.waddr(ram_req.waddr),
		.wdata(ram_req.wdata),
		.raddr(ram_req.raddr),
		.rdata(ram_rdata)
	);

	// Command sequencer.
	arq_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.start_item(req_item),
		.out_free  (out_free),
		.ram_rdata (ram_rdata),
		.ram_req   (ram_req),
		.busy      (busy),
		.done      (done)
	);

	// Output register: holds a result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done.valid) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done.valid) begin
			rsp_item_q <= done.result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

endmodule

`default_nettype wire
